// ===== rtl/plur_pkg.sv =====
// Package with shared codes, defaults and types for the posting list union rank block.
`default_nettype none
package plur_pkg;
    localparam int LIST_DEPTH_DEF = 4096;
    localparam int SCORE_BITS_DEF = 32;
    localparam int ID_BITS        = 32;
    localparam int LIMIT_BITS     = 14;
    localparam int STATUS_BITS    = 2;
    localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = 14'd8192;

    localparam logic [1:0] ACT_LOAD_A = 2'd0;
    localparam logic [1:0] ACT_LOAD_B = 2'd1;
    localparam logic [1:0] ACT_RUN    = 2'd2;
    localparam logic [1:0] ACT_READ   = 2'd3;

    localparam logic [STATUS_BITS-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_BITS-1:0] ST_OVERFLOW = 2'd1;
    localparam logic [STATUS_BITS-1:0] ST_PAST_END = 2'd2;

    // Decision of the shared compare unit
    typedef struct packed {
        logic take_a;
        logic take_b;
        logic done;
    } t_pick;
endpackage
`default_nettype wire

// ===== rtl/plur_ram.sv =====
// Generic RAM with one write port and two registered read ports.
`default_nettype none
module plur_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 8192
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr_a,
    output logic      [WIDTH-1:0]         o_rdata_a,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic      [WIDTH-1:0]         o_rdata_b
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write, then register both reads
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end
endmodule
`default_nettype wire

// ===== rtl/plur_cmp_unit.sv =====
// Shared compare and saturating add unit used by both merge and sort steps.
`default_nettype none
module plur_cmp_unit
    import plur_pkg::*;
#(
    parameter int SCORE_BITS = SCORE_BITS_DEF
) (
    input  wire logic                          i_sort,
    input  wire logic                          i_va,
    input  wire logic                          i_vb,
    input  wire logic [ID_BITS+SCORE_BITS-1:0] i_ent_a,
    input  wire logic [ID_BITS+SCORE_BITS-1:0] i_ent_b,
    output t_pick                              o_pick,
    output logic      [ID_BITS+SCORE_BITS-1:0] o_ent
);
    logic [ID_BITS-1:0]    id_a, id_b;
    logic [SCORE_BITS-1:0] sc_a, sc_b, sc_sum;
    logic [SCORE_BITS:0]   sum;

    assign id_a = i_ent_a[ID_BITS+SCORE_BITS-1:SCORE_BITS];
    assign id_b = i_ent_b[ID_BITS+SCORE_BITS-1:SCORE_BITS];
    assign sc_a = i_ent_a[SCORE_BITS-1:0];
    assign sc_b = i_ent_b[SCORE_BITS-1:0];
    assign sum  = {1'b0, sc_a} + {1'b0, sc_b};
    // Saturate on carry out
    assign sc_sum = sum[SCORE_BITS] ? {SCORE_BITS{1'b1}} : sum[SCORE_BITS-1:0];

    // Pick the next entry
    always_comb begin
        o_pick = '0;
        o_ent  = i_ent_a;
        if (!i_va && !i_vb) begin
            o_pick.done = 1'b1;
        end else if (i_sort) begin
            if (i_vb && (!i_va || sc_b > sc_a)) begin
                o_pick.take_b = 1'b1;
                o_ent         = i_ent_b;
            end else begin
                o_pick.take_a = 1'b1;
            end
        end else if (!i_va || (i_vb && id_a > id_b)) begin
            o_pick.take_b = 1'b1;
            o_ent         = i_ent_b;
        end else if (!i_vb || id_b > id_a) begin
            o_pick.take_a = 1'b1;
        end else begin
            o_pick.take_a = 1'b1;
            o_pick.take_b = 1'b1;
            o_ent         = {id_a, sc_sum};
        end
    end
endmodule
`default_nettype wire

// ===== rtl/posting_list_union_rank.sv =====
// Top level of the posting list union rank block: sequencer, stores and channels.
//
// Input channel (i_valid / o_stall) carries one action per item: load an entry
// into the first or second list, run the merge and sort, or read the next
// ranked entry. Output channel (o_valid / i_stall) returns one item for each
// run and each read; loads return nothing.
// Loads stream at one item per cycle while the block is idle and no result waits;
// an entry beyond the list depth is dropped and reported by the next run. A read
// passes through the S_READ state and the registered RAM read before its item is
// registered on the output; no new item is taken until that result is taken.
// A run merges the two lists through the shared compare unit, n being the union
// size, then sorts the union over ceil(log2 n) sort passes and ends in one final
// state; the shared compare unit and the two read ports of the ping-pong buffers
// set its pace.
// The block holds o_stall high while a run or a read is in progress and
// while a result waits; a stalled result holds until the receiver takes it.
// The result limit register is written through i_cfg_valid / o_cfg_ready,
// which is always ready.
// Reset clears counts, the read position, the overflow flag and the limit
// (to 8192); the stores keep their contents and need no clearing pass.
`default_nettype none
module posting_list_union_rank
    import plur_pkg::*;
#(
    parameter int LIST_DEPTH = LIST_DEPTH_DEF,
    parameter int SCORE_BITS = SCORE_BITS_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_valid,
    output logic                        o_stall,
    input  wire logic [1:0]             i_action,
    input  wire logic [ID_BITS-1:0]     i_doc_id,
    input  wire logic [31:0]            i_score,
    output logic                        o_valid,
    input  wire logic                   i_stall,
    output logic      [ID_BITS-1:0]     o_out_doc_id,
    output logic      [31:0]            o_out_score,
    output logic      [LIMIT_BITS-1:0]  o_result_count,
    output logic                        o_last,
    output logic      [STATUS_BITS-1:0] o_status,
    input  wire logic                   i_cfg_valid,
    output logic                        o_cfg_ready,
    input  wire logic [LIMIT_BITS-1:0]  i_cfg_data
);
    localparam int LAW = $clog2(LIST_DEPTH);
    localparam int LCW = LAW + 1;
    localparam int AW  = $clog2(2 * LIST_DEPTH);
    localparam int CW  = AW + 1;
    localparam int EW  = ID_BITS + SCORE_BITS;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_M_RD  = 4'd1;
    localparam logic [3:0] S_M_CMP = 4'd2;
    localparam logic [3:0] S_S_SET = 4'd3;
    localparam logic [3:0] S_S_RD  = 4'd4;
    localparam logic [3:0] S_S_CMP = 4'd5;
    localparam logic [3:0] S_FIN   = 4'd6;
    localparam logic [3:0] S_READ  = 4'd7;

    logic [3:0]            r_state;
    logic [LCW-1:0]        r_cnt_a, r_cnt_b, r_i, r_j;
    logic                  r_ovf, r_src;
    logic [CW-1:0]         r_rank, r_rp, r_n, r_k;
    logic [CW:0]           r_w, r_lo, r_mid, r_hi, r_a, r_b;
    logic [LIMIT_BITS-1:0] r_limit;
    logic                  r_ovalid;
    logic [ID_BITS-1:0]    r_oid;
    logic [31:0]           r_osc;
    logic                  r_olast;
    logic [STATUS_BITS-1:0] r_ostat;

    logic                  accept, load_ok, load_we;
    logic [AW-1:0]         list_waddr, list_ra, list_rb, buf_ra, buf_rb;
    logic [EW-1:0]         load_ent, list_da, list_db;
    logic [EW-1:0]         b0_da, b0_db, b1_da, b1_db, src_da, src_db;
    logic [EW-1:0]         cmp_a, cmp_b, cmp_ent;
    logic                  cmp_sort, cmp_va, cmp_vb;
    t_pick                 pick;
    logic                  b0_we, b1_we;
    logic [AW-1:0]         b_waddr;
    logic [CW:0]           n_ext, nlo, nw, mid_sum, hi_sum;
    logic [31:0]           n32, lim32;

    assign o_stall     = (r_state != S_IDLE) || r_ovalid;
    assign o_cfg_ready = 1'b1;
    assign accept      = i_valid && !o_stall;
    assign o_valid     = r_ovalid;
    assign o_out_doc_id   = r_oid;
    assign o_out_score    = r_osc;
    assign o_result_count = r_rank[LIMIT_BITS-1:0];
    assign o_last         = r_olast;
    assign o_status       = r_ostat;

    // Load path into the combined list store: first list low half, second high
    assign load_ok = (i_action == ACT_LOAD_A) ? (r_cnt_a < LCW'(LIST_DEPTH))
                                              : (r_cnt_b < LCW'(LIST_DEPTH));
    assign load_we = accept && (i_action == ACT_LOAD_A || i_action == ACT_LOAD_B) && load_ok;
    assign list_waddr = (i_action == ACT_LOAD_A) ? {1'b0, r_cnt_a[LAW-1:0]}
                                                 : {1'b1, r_cnt_b[LAW-1:0]};
    assign load_ent = {i_doc_id, i_score[SCORE_BITS-1:0]};
    assign list_ra  = {1'b0, r_i[LAW-1:0]};
    assign list_rb  = {1'b1, r_j[LAW-1:0]};

    plur_ram #(.WIDTH(EW), .DEPTH(2 ** AW)) u_lists (
        .i_clk     (i_clk),
        .i_we      (load_we),
        .i_waddr   (list_waddr),
        .i_wdata   (load_ent),
        .i_raddr_a (list_ra),
        .o_rdata_a (list_da),
        .i_raddr_b (list_rb),
        .o_rdata_b (list_db)
    );

    // Ping-pong buffers for merge output and sort passes
    assign buf_ra  = (r_state == S_S_RD) ? r_a[AW-1:0] : r_rp[AW-1:0];
    assign buf_rb  = r_b[AW-1:0];
    assign b_waddr = (r_state == S_M_CMP) ? r_n[AW-1:0] : r_k[AW-1:0];
    assign b0_we   = !pick.done && ((r_state == S_M_CMP) || (r_state == S_S_CMP && r_src));
    assign b1_we   = !pick.done && (r_state == S_S_CMP) && !r_src;

    plur_ram #(.WIDTH(EW), .DEPTH(2 ** AW)) u_buf0 (
        .i_clk     (i_clk),
        .i_we      (b0_we),
        .i_waddr   (b_waddr),
        .i_wdata   (cmp_ent),
        .i_raddr_a (buf_ra),
        .o_rdata_a (b0_da),
        .i_raddr_b (buf_rb),
        .o_rdata_b (b0_db)
    );

    plur_ram #(.WIDTH(EW), .DEPTH(2 ** AW)) u_buf1 (
        .i_clk     (i_clk),
        .i_we      (b1_we),
        .i_waddr   (b_waddr),
        .i_wdata   (cmp_ent),
        .i_raddr_a (buf_ra),
        .o_rdata_a (b1_da),
        .i_raddr_b (buf_rb),
        .o_rdata_b (b1_db)
    );

    assign src_da = r_src ? b1_da : b0_da;
    assign src_db = r_src ? b1_db : b0_db;

    // Feed the shared compare unit
    assign cmp_sort = (r_state == S_S_CMP);
    assign cmp_a    = cmp_sort ? src_da : list_da;
    assign cmp_b    = cmp_sort ? src_db : list_db;
    assign cmp_va   = cmp_sort ? (r_a < r_mid) : (r_i < r_cnt_a);
    assign cmp_vb   = cmp_sort ? (r_b < r_hi)  : (r_j < r_cnt_b);

    plur_cmp_unit #(.SCORE_BITS(SCORE_BITS)) u_cmp (
        .i_sort  (cmp_sort),
        .i_va    (cmp_va),
        .i_vb    (cmp_vb),
        .i_ent_a (cmp_a),
        .i_ent_b (cmp_b),
        .o_pick  (pick),
        .o_ent   (cmp_ent)
    );

    assign n_ext   = {1'b0, r_n};
    assign nlo     = r_lo + (r_w << 1);
    assign nw      = r_w << 1;
    assign mid_sum = r_lo + r_w;
    assign hi_sum  = r_lo + (r_w << 1);
    assign n32     = 32'(r_n);
    assign lim32   = 32'(r_limit);

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LIMIT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_limit <= i_cfg_data;
        end
    end

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt_a  <= '0;
            r_cnt_b  <= '0;
            r_ovf    <= 1'b0;
            r_rank   <= '0;
            r_rp     <= '0;
            r_ovalid <= 1'b0;
            r_src    <= 1'b0;
        end else begin
            if (r_ovalid && !i_stall) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        case (i_action)
                            ACT_LOAD_A: begin
                                if (load_ok) r_cnt_a <= r_cnt_a + 1'b1;
                                else         r_ovf   <= 1'b1;
                            end
                            ACT_LOAD_B: begin
                                if (load_ok) r_cnt_b <= r_cnt_b + 1'b1;
                                else         r_ovf   <= 1'b1;
                            end
                            ACT_RUN: begin
                                r_i     <= '0;
                                r_j     <= '0;
                                r_n     <= '0;
                                r_state <= S_M_RD;
                            end
                            default: begin
                                if (r_rp < r_rank) begin
                                    r_state <= S_READ;
                                end else begin
                                    r_oid    <= '0;
                                    r_osc    <= '0;
                                    r_olast  <= 1'b0;
                                    r_ostat  <= ST_PAST_END;
                                    r_ovalid <= 1'b1;
                                end
                            end
                        endcase
                    end
                end
                S_M_RD: begin
                    r_state <= S_M_CMP;
                end
                S_M_CMP: begin
                    if (pick.done) begin
                        r_src <= 1'b0;
                        r_w   <= (CW+1)'(1);
                        r_lo  <= '0;
                        r_state <= (r_n > CW'(1)) ? S_S_SET : S_FIN;
                    end else begin
                        r_n <= r_n + 1'b1;
                        if (pick.take_a) r_i <= r_i + 1'b1;
                        if (pick.take_b) r_j <= r_j + 1'b1;
                        r_state <= S_M_RD;
                    end
                end
                S_S_SET: begin
                    r_mid   <= (mid_sum > n_ext) ? n_ext : mid_sum;
                    r_hi    <= (hi_sum > n_ext) ? n_ext : hi_sum;
                    r_a     <= r_lo;
                    r_b     <= (mid_sum > n_ext) ? n_ext : mid_sum;
                    r_k     <= r_lo[CW-1:0];
                    r_state <= S_S_RD;
                end
                S_S_RD: begin
                    r_state <= S_S_CMP;
                end
                S_S_CMP: begin
                    if (pick.done) begin
                        if (nlo >= n_ext) begin
                            r_src <= !r_src;
                            r_w   <= nw;
                            r_lo  <= '0;
                            r_state <= (nw >= n_ext) ? S_FIN : S_S_SET;
                        end else begin
                            r_lo    <= nlo;
                            r_state <= S_S_SET;
                        end
                    end else begin
                        r_k <= r_k + 1'b1;
                        if (pick.take_a) r_a <= r_a + 1'b1;
                        else             r_b <= r_b + 1'b1;
                        r_state <= S_S_RD;
                    end
                end
                S_FIN: begin
                    r_rank   <= (n32 > lim32) ? CW'(r_limit) : r_n;
                    r_rp     <= '0;
                    r_oid    <= '0;
                    r_osc    <= '0;
                    r_olast  <= 1'b0;
                    r_ostat  <= r_ovf ? ST_OVERFLOW : ST_OK;
                    r_ovalid <= 1'b1;
                    r_cnt_a  <= '0;
                    r_cnt_b  <= '0;
                    r_ovf    <= 1'b0;
                    r_state  <= S_IDLE;
                end
                S_READ: begin
                    r_oid    <= src_da[EW-1:SCORE_BITS];
                    r_osc    <= 32'(src_da[SCORE_BITS-1:0]);
                    r_olast  <= (r_rp + 1'b1) == r_rank;
                    r_ostat  <= ST_OK;
                    r_ovalid <= 1'b1;
                    r_rp     <= r_rp + 1'b1;
                    r_state  <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Read position never runs past the ranked count
    a_rp_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rp <= r_rank) else $error("read position beyond ranked count");

    // List counts never exceed the depth
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt_a <= LCW'(LIST_DEPTH) && r_cnt_b <= LCW'(LIST_DEPTH))
        else $error("list count beyond depth");

    // Sort output index tracks both run heads
    a_sort_k: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_S_RD || r_state == S_S_CMP) |-> ({1'b0, r_k} + r_mid == r_a + r_b))
        else $error("sort write index out of step");

    // A final entry is only ever reported with good status
    a_last_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_olast) |-> (r_ostat == ST_OK))
        else $error("last flag with bad status");
endmodule
`default_nettype wire
